/* rtl/core/symmetric_fir_line_filter_mirror_edges_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the line filter RTL.
// Both expect clk_i and rst_ni in scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_FIR_LINE_FILTER_MIRROR_EDGES_ASSERT_SVH
`define SYMMETRIC_FIR_LINE_FILTER_MIRROR_EDGES_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SFIR_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfir: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SFIR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfir: next-cycle check failed");

`endif

/* rtl/core/sfir_pkg.sv */
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants, register codes and types of the symmetric line filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfir_pkg;

  // Default build parameters.
  localparam int unsigned RADIUS_MAX_DEF  = 3;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Sample history and line position counter.
  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned SLOT_BITS = $clog2(WIN_DEPTH);
  localparam int unsigned POS_BITS  = $clog2(WIN_DEPTH) + 1;

  // Unsigned Q1.16 weights, one per tap distance 0..3.
  localparam int unsigned WEIGHT_BITS  = 17;
  localparam int unsigned NUM_WEIGHTS  = 4;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned ROUND_HALF   = 32768;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_UNITY = 17'h10000;

  // Configuration port.
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned RADIUS_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_W_CENTER = 3'd0,
    CFG_W_ONE    = 3'd1,
    CFG_W_TWO    = 3'd2,
    CFG_W_THREE  = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_MODE     = 3'd5
  } cfg_reg_e;

  // Control that travels along with one beat through the datapath.
  typedef struct packed {
    logic valid;
    logic last;
  } sfir_beat_t;

endpackage

/* rtl/core/sfir_window.sv */
// ----------------------------------------------------------------------------
// sfir_window
// Sample history, line position, output sequencer and edge folding. While
// en_i is high, each cycle it issues one output position and registers the symmetric tap sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "symmetric_fir_line_filter_mirror_edges_assert.svh"

module sfir_window #(
  parameter int unsigned RADIUS_MAX  = sfir_pkg::RADIUS_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                 in_sample_i,
  input  logic                                   in_eol_i,
  input  logic [sfir_pkg::RADIUS_BITS-1:0]       radius_i,
  input  logic                                   mirror_neg_i,
  output sfir_pkg::sfir_beat_t                   beat_o,
  output logic signed [SAMPLE_BITS+1:0]          term_o [RADIUS_MAX+1]
);

  localparam int unsigned TW  = SAMPLE_BITS + 2;
  localparam int unsigned SB1 = SAMPLE_BITS + 1;
  localparam int unsigned PB  = sfir_pkg::POS_BITS;
  localparam int unsigned NB  = sfir_pkg::SLOT_BITS;

  // Sample history, newest in slot zero, and samples seen in this line.
  logic [SAMPLE_BITS-1:0] win_q [sfir_pkg::WIN_DEPTH];
  logic [PB-1:0]          pos_q, pos_d;

  // Issue stage: output positions iss_n_q..iss_end_q of the current item.
  logic          iss_valid_q, iss_valid_d;
  logic [NB-1:0] iss_n_q, iss_n_d;
  logic [NB-1:0] iss_end_q, iss_end_d;
  logic [PB-1:0] iss_c_q, iss_c_d;
  logic          iss_eol_q, iss_eol_d;

  logic          accept;
  logic          iss_done;
  logic [PB-1:0] c_new;
  logic [PB-1:0] r_ext;

  sfir_pkg::sfir_beat_t           beat_q, beat_d;
  logic signed [TW-1:0]           term_q [RADIUS_MAX+1];
  logic signed [TW-1:0]           term_d [RADIUS_MAX+1];

  // Map a line index to a history slot. While the line runs only the left
  // edge mirrors; at the line end the mirroring repeats with period 2*c.
  function automatic logic [NB:0] fold(input logic signed [4:0] idx,
                                       input logic [PB-1:0]     cnt,
                                       input logic              at_end);
    int   ii;
    int   per;
    int   cn;
    logic neg;
    ii  = int'(idx);
    cn  = int'(cnt);
    per = 2 * cn;
    neg = 1'b0;
    if (!at_end) begin
      if (ii < 0) begin
        ii  = -ii - 1;
        neg = 1'b1;
      end
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (ii < 0) ii = ii + per;
      end
      for (int k = 0; k < 5; k++) begin
        if (ii >= per) ii = ii - per;
      end
      if (ii >= cn) begin
        ii  = per - 1 - ii;
        neg = 1'b1;
      end
    end
    return {neg, NB'(cn - 1 - ii)};
  endfunction

  // Fetch a folded sample, negated for mirrored copies in Dirichlet mode.
  function automatic logic signed [SB1-1:0] pick(input logic [NB:0] f);
    logic signed [SB1-1:0] v;
    v = SB1'($signed(win_q[f[NB-1:0]]));
    if (f[NB] && mirror_neg_i) v = -v;
    return v;
  endfunction

  assign iss_done   = !iss_valid_q || (iss_n_q == iss_end_q);
  assign in_ready_o = en_i && iss_done;
  assign accept     = in_valid_i && in_ready_o;
  assign r_ext      = PB'(radius_i);
  assign c_new      = (pos_q == PB'(sfir_pkg::WIN_DEPTH)) ? pos_q : pos_q + 1'b1;

  // Sequencer: step through owed outputs, load a new item when done.
  always_comb begin
    iss_valid_d = iss_valid_q;
    iss_n_d     = iss_n_q;
    iss_end_d   = iss_end_q;
    iss_c_d     = iss_c_q;
    iss_eol_d   = iss_eol_q;
    pos_d       = pos_q;
    if (en_i) begin
      if (!iss_done) begin
        iss_n_d = iss_n_q + 1'b1;
      end else if (accept) begin
        iss_c_d   = c_new;
        iss_eol_d = in_eol_i;
        iss_end_d = NB'(c_new - 1'b1);
        if (in_eol_i) begin
          // Flush the rest of the line, at most radius+1 outputs.
          iss_valid_d = 1'b1;
          iss_n_d     = (c_new > r_ext + 1'b1) ? NB'(c_new - 1'b1 - r_ext) : '0;
          pos_d       = '0;
        end else begin
          iss_valid_d = (c_new > r_ext);
          iss_n_d     = NB'(c_new - 1'b1 - r_ext);
          iss_end_d   = NB'(c_new - 1'b1 - r_ext);
          pos_d       = c_new;
        end
      end else begin
        iss_valid_d = 1'b0;
      end
    end
  end

  // Gather and pre-add the symmetric taps of the issued position.
  always_comb begin
    logic signed [4:0] ctr;
    ctr         = $signed({2'b00, iss_n_q});
    beat_d      = beat_q;
    beat_d.valid = iss_valid_q;
    beat_d.last  = iss_eol_q && (iss_n_q == iss_end_q);
    for (int p = 0; p <= RADIUS_MAX; p++) begin
      if (p == 0) begin
        term_d[p] = TW'(pick(fold(ctr, iss_c_q, iss_eol_q)));
      end else if (p <= int'(radius_i)) begin
        term_d[p] = TW'(pick(fold(ctr + 5'(p), iss_c_q, iss_eol_q)))
                  + TW'(pick(fold(ctr - 5'(p), iss_c_q, iss_eol_q)));
      end else begin
        term_d[p] = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      iss_valid_q <= 1'b0;
      iss_n_q     <= '0;
      iss_end_q   <= '0;
      iss_c_q     <= '0;
      iss_eol_q   <= 1'b0;
      beat_q      <= '0;
    end else begin
      pos_q       <= pos_d;
      iss_valid_q <= iss_valid_d;
      iss_n_q     <= iss_n_d;
      iss_end_q   <= iss_end_d;
      iss_c_q     <= iss_c_d;
      iss_eol_q   <= iss_eol_d;
      if (en_i) beat_q <= beat_d;
    end
  end

  // Sample history shifts on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(sfir_pkg::WIN_DEPTH); i++) win_q[i] <= '0;
    end else if (accept) begin
      win_q[0] <= in_sample_i;
      for (int i = 1; i < int'(sfir_pkg::WIN_DEPTH); i++) win_q[i] <= win_q[i-1];
    end
  end

  // Tap sums are payload and carry no reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p <= RADIUS_MAX; p++) term_q[p] <= term_d[p];
    end
  end

  assign beat_o = beat_q;
  assign term_o = term_q;

  `SFIR_ASSERT_NEXT(a_eol_clears_pos, accept && in_eol_i, pos_q == '0)
  `SFIR_ASSERT(a_iss_order, iss_valid_q, iss_n_q <= iss_end_q)
  `SFIR_ASSERT(a_iss_in_line, iss_valid_q, {1'b0, iss_end_q} < iss_c_q)
  `SFIR_ASSERT(a_no_accept_mid_flush, iss_valid_q && (iss_n_q != iss_end_q), !in_ready_o)

endmodule

/* rtl/core/sfir_mac.sv */
// ----------------------------------------------------------------------------
// sfir_mac
// Weights the tap sums, adds them up, rounds to nearest and saturates.
// Ends in the output register that drives the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfir_mac #(
  parameter int unsigned RADIUS_MAX  = sfir_pkg::RADIUS_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  sfir_pkg::sfir_beat_t                 beat_i,
  input  logic signed [SAMPLE_BITS+1:0]        term_i [RADIUS_MAX+1],
  input  logic [sfir_pkg::WEIGHT_BITS-1:0]     weight_i [sfir_pkg::NUM_WEIGHTS],
  output logic                                 out_valid_o,
  output logic                                 out_last_o,
  output logic [SAMPLE_BITS-1:0]               out_sample_o
);

  localparam int unsigned TW = SAMPLE_BITS + 2;
  localparam int unsigned PW = TW + sfir_pkg::WEIGHT_BITS + 1;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned FB = sfir_pkg::FRAC_BITS;
  localparam int unsigned QW = AW - FB;
  localparam logic signed [QW-1:0] QHI = {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] QLO = ~QHI;

  sfir_pkg::sfir_beat_t   beat_q;
  logic signed [PW-1:0]   prod_q [RADIUS_MAX+1];
  logic signed [AW-1:0]   acc;
  logic signed [QW-1:0]   quo;
  logic [SAMPLE_BITS-1:0] sat;

  logic                   o_valid_q;
  logic                   o_last_q;
  logic [SAMPLE_BITS-1:0] o_sample_q;

  // One multiplier per tap distance, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p <= RADIUS_MAX; p++) begin
        prod_q[p] <= $signed({1'b0, weight_i[p]}) * term_i[p];
      end
    end
  end

  // Sum, add one half, floor-shift and clamp to the sample range.
  always_comb begin
    acc = AW'($signed(sfir_pkg::ROUND_HALF));
    for (int p = 0; p <= RADIUS_MAX; p++) acc = acc + AW'(prod_q[p]);
    quo = acc[AW-1:FB];
    if (quo > QHI) begin
      sat = QHI[SAMPLE_BITS-1:0];
    end else if (quo < QLO) begin
      sat = QLO[SAMPLE_BITS-1:0];
    end else begin
      sat = quo[SAMPLE_BITS-1:0];
    end
  end

  // Beat control and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q    <= '0;
      o_valid_q <= 1'b0;
      o_last_q  <= 1'b0;
    end else if (en_i) begin
      beat_q    <= beat_i;
      o_valid_q <= beat_q.valid;
      o_last_q  <= beat_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) o_sample_q <= sat;
  end

  assign out_valid_o  = o_valid_q;
  assign out_last_o   = o_last_q;
  assign out_sample_o = o_sample_q;

endmodule

/* rtl/core/symmetric_fir_line_filter_mirror_edges.sv */
// ----------------------------------------------------------------------------
// symmetric_fir_line_filter_mirror_edges
// Symmetric FIR smoother over one image line with mirrored line edges.
// Path: an accepted input beat passes the issue registers, the tap sum register,
// the product register and the output register before its first result
// appears on the master side; further flush beats follow one per cycle while the master side is ready.
// Throughput: one sample per cycle while the master side is ready; a line-end
// sample owes up to radius+1 results and holds the slave side while they issue.
// Reset clears the pipeline, history and line position and loads the default
// weights (unity center), radius one and plain mirroring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symmetric_fir_line_filter_mirror_edges #(
  parameter int unsigned RADIUS_MAX  = sfir_pkg::RADIUS_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Slave stream. tdata: sample_in, padded with zeros to whole bytes.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tlast,
  // Master stream. tdata: sample_out, padded with zeros to whole bytes.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sfir_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [sfir_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [sfir_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  localparam int unsigned DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned WB = sfir_pkg::WEIGHT_BITS;
  localparam int unsigned RB = sfir_pkg::RADIUS_BITS;

  // Configuration registers.
  logic [WB-1:0] weight_q [sfir_pkg::NUM_WEIGHTS];
  logic [RB-1:0] radius_q;
  logic          mode_q;
  logic          cfg_write;
  logic [RB-1:0] radius_eff;
  sfir_pkg::cfg_reg_e cfg_sel;

  logic                         en;
  sfir_pkg::sfir_beat_t         beat;
  logic signed [SAMPLE_BITS+1:0] term [RADIUS_MAX+1];
  logic                         out_valid;
  logic                         out_last;
  logic [SAMPLE_BITS-1:0]       out_sample;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = sfir_pkg::cfg_reg_e'(paddr[sfir_pkg::CFG_ADDR_BITS-1:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q[0] <= sfir_pkg::WEIGHT_UNITY;
      for (int i = 1; i < int'(sfir_pkg::NUM_WEIGHTS); i++) weight_q[i] <= '0;
      radius_q <= RB'(1);
      mode_q   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        sfir_pkg::CFG_W_CENTER: weight_q[0] <= pwdata[WB-1:0];
        sfir_pkg::CFG_W_ONE:    weight_q[1] <= pwdata[WB-1:0];
        sfir_pkg::CFG_W_TWO:    weight_q[2] <= pwdata[WB-1:0];
        sfir_pkg::CFG_W_THREE:  weight_q[3] <= pwdata[WB-1:0];
        sfir_pkg::CFG_RADIUS:   radius_q    <= pwdata[RB-1:0];
        sfir_pkg::CFG_MODE:     mode_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      sfir_pkg::CFG_W_CENTER: prdata = sfir_pkg::CFG_DATA_BITS'(weight_q[0]);
      sfir_pkg::CFG_W_ONE:    prdata = sfir_pkg::CFG_DATA_BITS'(weight_q[1]);
      sfir_pkg::CFG_W_TWO:    prdata = sfir_pkg::CFG_DATA_BITS'(weight_q[2]);
      sfir_pkg::CFG_W_THREE:  prdata = sfir_pkg::CFG_DATA_BITS'(weight_q[3]);
      sfir_pkg::CFG_RADIUS:   prdata = sfir_pkg::CFG_DATA_BITS'(radius_q);
      sfir_pkg::CFG_MODE:     prdata = sfir_pkg::CFG_DATA_BITS'(mode_q);
      default:                prdata = '0;
    endcase
  end

  // A radius of zero acts as one; anything above the build limit is clamped.
  always_comb begin
    if (radius_q == '0) begin
      radius_eff = RB'(1);
    end else if (int'(radius_q) > int'(RADIUS_MAX)) begin
      radius_eff = RB'(RADIUS_MAX);
    end else begin
      radius_eff = radius_q;
    end
  end

  // The whole pipeline moves whenever the output register can take a beat.
  assign en = !out_valid || m_axis_tready;

  sfir_window #(
    .RADIUS_MAX  (RADIUS_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_eol_i     (s_axis_tlast),
    .radius_i     (radius_eff),
    .mirror_neg_i (mode_q),
    .beat_o       (beat),
    .term_o       (term)
  );

  sfir_mac #(
    .RADIUS_MAX  (RADIUS_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .beat_i       (beat),
    .term_i       (term),
    .weight_i     (weight_q),
    .out_valid_o  (out_valid),
    .out_last_o   (out_last),
    .out_sample_o (out_sample)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = DW'(out_sample);

endmodule

/* bench/tb_symmetric_fir_line_filter_mirror_edges.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_symmetric_fir_line_filter_mirror_edges
// Streams image lines through the symmetric line smoother and checks every
// filtered beat against a cycle-free predictor of the filter or typed results.
// The predictor keeps its own sample history and register copy. A short
// stimulus table covers the reset weights, the field extremes, short lines,
// saturation, an out-of-range radius and both edge modes. Random lines under
// random weights follow. Both stream sides idle at random, and the result side
// holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------

module tb_symmetric_fir_line_filter_mirror_edges;
  import sfir_pkg::*;

  localparam int SAMPLE_W        = 16;
  localparam int TDATA_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int LONG_HOLD       = 300;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 46;
  localparam longint SAT_HI      = 32767;
  localparam longint SAT_LO      = -32768;
  localparam logic [31:0] WEIGHT_MASK = (32'd1 << WEIGHT_BITS) - 1;

  // One filtered sample as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } line_result_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed table: a register write or a sample beat.
  // Typed rows carry their results; other rows go through the predictor.
  typedef struct packed {
    row_kind_e           kind;
    cfg_reg_e            idx;
    logic [31:0]         value;
    logic                eol;
    logic                typed;
    logic [1:0]          n_typed;
    logic [SAMPLE_W-1:0] exp_a;
    logic [SAMPLE_W-1:0] exp_b;
  } stim_row_t;

  // Block ports.
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [TDATA_W-1:0]             s_axis_tdata  = '0;  // [15:0] sample_in
  logic                           s_axis_tlast  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]             m_axis_tdata;        // [15:0] sample_out
  logic                           m_axis_tlast;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [CFG_ADDR_BITS-1:0]       paddr         = '0;
  logic [CFG_DATA_BITS-1:0]       pwdata        = '0;
  logic [CFG_DATA_BITS-1:0]       prdata;
  logic                           pready;

  // Predictor state and register copy.
  longint       hist_model [WIN_DEPTH];
  int           pos_model;
  longint       wgt_model [NUM_WEIGHTS];
  int           radius_model;
  logic         mode_model;

  line_result_t step_results [$];
  line_result_t owed_results [$];
  stim_row_t    stim_table [$];

  int           mismatches    = 0;
  int           cycle_count   = 0;
  logic         sender_calm   = 1'b0;
  logic         long_hold_go  = 1'b0;
  logic         line_busy     = 1'b0;

  symmetric_fir_line_filter_mirror_edges dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample at line index i with mirrored edges. While the line is still
  // running (len of zero) only the left edge can be crossed; at the line end
  // the mirroring repeats with a period of twice the line length.
  function automatic longint tap_value(input int i, input int held, input int len);
    logic   flip;
    int     period;
    longint v;
    flip = 1'b0;
    if (len == 0) begin
      if (i < 0) begin
        i = -i - 1;
        flip = 1'b1;
      end
    end else begin
      period = 2 * len;
      while (i < 0) i = i + period;
      while (i >= period) i = i - period;
      if (i >= len) begin
        i = period - 1 - i;
        flip = 1'b1;
      end
    end
    v = hist_model[(held - 1 - i) & (WIN_DEPTH - 1)];
    // Dirichlet mode negates every mirrored copy.
    if (flip && mode_model) v = -v;
    return v;
  endfunction

  // Weighted symmetric sum around index n, rounded half up and saturated.
  function automatic logic [SAMPLE_W-1:0] smooth_at(input int n, input int held,
                                                    input int len, input int r);
    longint acc;
    longint q;
    int     p;
    acc = wgt_model[0] * tap_value(n, held, len);
    for (p = 1; p <= r; p++)
      acc = acc + wgt_model[p] * (tap_value(n + p, held, len) + tap_value(n - p, held, len));
    q = (acc + longint'(ROUND_HALF)) >>> FRAC_BITS;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[SAMPLE_W-1:0];
  endfunction

  // Advances the predictor by one input beat; the results land in step_results.
  function automatic void filter_step(input logic [SAMPLE_W-1:0] s, input logic eol);
    int           held;
    int           r;
    int           first;
    int           n;
    int           k;
    line_result_t res;
    step_results.delete();
    for (k = WIN_DEPTH - 1; k > 0; k--) hist_model[k] = hist_model[k-1];
    hist_model[0] = longint'($signed(s));
    if (pos_model < WIN_DEPTH) pos_model++;
    held = pos_model;
    // A radius of zero behaves as one.
    r = (radius_model == 0) ? 1 : radius_model;
    if (!eol) begin
      if (held > r) begin
        res.value = smooth_at(held - 1 - r, held, 0, r);
        res.last  = 1'b0;
        step_results.push_back(res);
      end
    end else begin
      // Flush everything still owed for the line, one per sample on short lines.
      first = held - 1 - r;
      if (first < 0) first = 0;
      for (n = first; n < held; n++) begin
        res.value = smooth_at(n, held, held, r);
        res.last  = (n == held - 1);
        step_results.push_back(res);
      end
      pos_model = 0;
    end
  endfunction

  function automatic void add_beat(input int s, input logic eol);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_BEAT;
    row.value = s;
    row.eol   = eol;
    stim_table.push_back(row);
  endfunction

  function automatic void add_typed(input int s, input logic eol, input int n,
                                    input int a, input int b);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_BEAT;
    row.value   = s;
    row.eol     = eol;
    row.typed   = 1'b1;
    row.n_typed = 2'(n);
    row.exp_a   = SAMPLE_W'(a);
    row.exp_b   = SAMPLE_W'(b);
    stim_table.push_back(row);
  endfunction

  function automatic void add_write(input cfg_reg_e idx, input int value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    stim_table.push_back(row);
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(0, 131071);
      default: return $urandom_range(0, 24000);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return raw[SAMPLE_W-1:0];
    endcase
  endfunction

  // One configuration transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input cfg_reg_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy   = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a register, reads it back and mirrors it into the predictor.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    logic [31:0] back;
    logic [31:0] kept;
    apb_access(1'b1, idx, value, back);
    apb_access(1'b0, idx, '0, back);
    case (idx)
      CFG_RADIUS: begin
        kept = value & 32'd3;
        radius_model = kept;
      end
      CFG_MODE: begin
        kept = value & 32'd1;
        mode_model = kept[0];
      end
      default: begin
        kept = value & WEIGHT_MASK;
        wgt_model[int'(idx)] = kept;
      end
    endcase
    if (back !== kept) begin
      $display("%0t: register %s read back: expected %0d, actual %0d",
               $time, idx.name(), kept, back);
      mismatches++;
    end
  endtask

  // Lets all owed results drain, then gives the pipeline time to go idle.
  task automatic quiesce();
    if (line_busy) begin
      s_axis_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      line_busy = 1'b0;
    end
  endtask

  // Offers one sample beat after a random gap and books its results.
  task automatic feed_sample(input stim_row_t row);
    int           gap;
    logic         took;
    line_result_t res;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.value[SAMPLE_W-1:0];
    s_axis_tlast  <= row.eol;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    line_busy = 1'b1;
    filter_step(row.value[SAMPLE_W-1:0], row.eol);
    if (row.typed) begin
      if (row.n_typed > 0) begin
        res.value = row.exp_a;
        res.last  = row.eol && (row.n_typed == 1);
        owed_results.push_back(res);
      end
      if (row.n_typed > 1) begin
        res.value = row.exp_b;
        res.last  = row.eol;
        owed_results.push_back(res);
      end
    end else begin
      foreach (step_results[j]) owed_results.push_back(step_results[j]);
    end
  endtask

  // Result side: random stalls per beat, calm stretches, and one long hold.
  initial begin : result_sink
    int   gap;
    int   taken;
    logic took;
    logic calm;
    logic hold_done;
    taken     = 0;
    calm      = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
      taken++;
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
    end
  end

  // Result checker: each beat taken is compared with the oldest owed result.
  always @(negedge clk_i) begin : check_results
    line_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0d last %b",
                 $time, $signed(m_axis_tdata[SAMPLE_W-1:0]), m_axis_tlast);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want.value) begin
          $display("%0t: sample_out: expected %0d, actual %0d", $time,
                   $signed(want.value), $signed(m_axis_tdata[SAMPLE_W-1:0]));
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_of_line: expected %b, actual %b", $time,
                   want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table first, then random lines under random weights.
  initial begin : stimulus
    int        ph;
    int        sent;
    int        len;
    int        k;
    stim_row_t row;

    for (k = 0; k < WIN_DEPTH; k++) hist_model[k] = 0;
    pos_model    = 0;
    wgt_model[0] = 65536;
    wgt_model[1] = 0;
    wgt_model[2] = 0;
    wgt_model[3] = 0;
    radius_model = 1;
    mode_model   = 1'b0;

    // Reset weights pass the samples through, delayed by one beat.
    add_typed(32767, 1'b0, 0, 0, 0);
    add_typed(-32768, 1'b0, 1, 32767, 0);
    add_typed(21845, 1'b1, 2, -32768, 21845);
    // A line of a single sample mirrors onto itself.
    add_typed(-1, 1'b1, 1, -1, 0);
    // Binomial-like weights with plain mirroring.
    add_write(CFG_W_CENTER, 32768);
    add_write(CFG_W_ONE, 16384);
    add_write(CFG_RADIUS, 1);
    add_write(CFG_MODE, 0);
    add_beat(1000, 1'b0);
    add_beat(-2000, 1'b0);
    add_beat(3000, 1'b0);
    add_beat(4, 1'b1);
    // Weights above one, full radius and negated mirroring drive saturation.
    add_write(CFG_W_CENTER, 65536);
    add_write(CFG_W_ONE, 131071);
    add_write(CFG_W_TWO, 131071);
    add_write(CFG_W_THREE, 131071);
    add_write(CFG_RADIUS, 3);
    add_write(CFG_MODE, 1);
    // Lines shorter than the radius, then a line that fills the history.
    add_beat(100, 1'b0);
    add_beat(200, 1'b1);
    add_beat(-32768, 1'b1);
    add_beat(32767, 1'b0);
    add_beat(32767, 1'b0);
    add_beat(-32768, 1'b0);
    add_beat(32767, 1'b0);
    add_beat(0, 1'b0);
    add_beat(-32768, 1'b0);
    add_beat(32767, 1'b0);
    add_beat(1, 1'b0);
    add_beat(-1, 1'b1);
    // A radius of zero acts as one; all-zero weights give zero out.
    add_write(CFG_RADIUS, 0);
    add_write(CFG_W_CENTER, 0);
    add_write(CFG_W_ONE, 0);
    add_write(CFG_W_TWO, 0);
    add_write(CFG_W_THREE, 0);
    add_write(CFG_MODE, 0);
    add_typed(12345, 1'b0, 0, 0, 0);
    add_typed(-12345, 1'b1, 2, 0, 0);
    // Radius two with negated mirroring.
    add_write(CFG_RADIUS, 2);
    add_write(CFG_MODE, 1);
    add_write(CFG_W_CENTER, 40000);
    add_write(CFG_W_ONE, 10000);
    add_write(CFG_W_TWO, 2768);
    add_beat(500, 1'b0);
    add_beat(-700, 1'b0);
    add_beat(900, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        quiesce();
        write_reg(stim_table[i].idx, stim_table[i].value);
      end else begin
        feed_sample(stim_table[i]);
      end
    end

    // Random phases: new weights each phase, then whole lines of random samples.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      write_reg(CFG_W_CENTER, pick_weight());
      write_reg(CFG_W_ONE, pick_weight());
      write_reg(CFG_W_TWO, pick_weight());
      write_reg(CFG_W_THREE, pick_weight());
      write_reg(CFG_RADIUS, $urandom_range(0, 3));
      write_reg(CFG_MODE, $urandom_range(0, 1));
      // The third phase streams back to back while the result side holds off.
      sender_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == 2) long_hold_go <= 1'b1;
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        for (k = 0; k < len; k++) begin
          row       = '0;
          row.kind  = ROW_BEAT;
          row.value = pick_sample();
          row.eol   = (k == len - 1);
          feed_sample(row);
          sent++;
        end
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
